[design/tsfl_pkg.sv]
// Shared types, codes and constants for the touch sample filter and latch.
`timescale 1ns / 1ps

package tsfl_pkg;

  localparam int COORD_BITS = 12;
  localparam int CNT_BITS   = 32;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = 1;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
  // Manhattan move that must be exceeded before the kept position follows the contact
  localparam logic [COORD_BITS:0] MOVE_THRESH = (COORD_BITS + 1)'(3);
  localparam logic [3:0] MAX_CONTACTS = 4'd2;

  // input action codes
  localparam logic [1:0] ACT_SAMPLE  = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  // register indexes
  localparam logic [1:0] REG_PANEL_HEIGHT   = 2'd0;
  localparam logic [1:0] REG_PANEL_WIDTH    = 2'd1;
  localparam logic [1:0] REG_DEVICE_PRESENT = 2'd2;

  localparam logic [COORD_BITS-1:0] PANEL_HEIGHT_RST = COORD_BITS'(480);
  localparam logic [COORD_BITS-1:0] PANEL_WIDTH_RST  = COORD_BITS'(800);

  // classified operation codes
  localparam logic [2:0] OP_NOP     = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_REJECT  = 3'd2;
  localparam logic [2:0] OP_TOUCH   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] status_byte;
    logic [7:0] x_high;
    logic [7:0] x_low;
    logic [7:0] y_high;
    logic [7:0] y_low;
  } sample_t;

  typedef struct packed {
    logic                  touched;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  from_latch;
    logic                  rejected;
    logic [CNT_BITS-1:0]   error_count;
  } result_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] panel_height;
    logic [COORD_BITS-1:0] panel_width;
    logic                  device_present;
  } cfg_t;

  typedef struct packed {
    logic [2:0]            op;
    logic [1:0]            count;
    logic [COORD_BITS-1:0] mx;
    logic [COORD_BITS-1:0] my;
  } cmd_t;

endpackage

[design/tsfl_front.sv]
// Front end: decodes a report word into a classified command with rotated coordinates.
`timescale 1ns / 1ps

module tsfl_front (
  input  tsfl_pkg::sample_t sample,
  input  tsfl_pkg::cfg_t    cfg,
  output tsfl_pkg::cmd_t    cmd
);

  logic [3:0]                      count;
  logic [tsfl_pkg::COORD_BITS-1:0] raw_x;
  logic [tsfl_pkg::COORD_BITS-1:0] raw_y;

  assign count = sample.status_byte[3:0];
  assign raw_x = tsfl_pkg::COORD_BITS'({sample.x_high[3:0], sample.x_low});
  assign raw_y = tsfl_pkg::COORD_BITS'({sample.y_high[3:0], sample.y_low});

  always_comb begin
    cmd.count = count[1:0];
    cmd.mx    = raw_y;
    // only used when raw_x is in range, so no wrap
    cmd.my    = cfg.panel_height - tsfl_pkg::COORD_BITS'(1) - raw_x;
    case (sample.action)
      tsfl_pkg::ACT_SAMPLE: begin
        if (count == 4'd0 || count > tsfl_pkg::MAX_CONTACTS) begin
          cmd.op = tsfl_pkg::OP_RELEASE;
        end else if (raw_x >= cfg.panel_height || raw_y >= cfg.panel_width) begin
          cmd.op = tsfl_pkg::OP_REJECT;
        end else begin
          cmd.op = tsfl_pkg::OP_TOUCH;
        end
      end
      tsfl_pkg::ACT_RELEASE: cmd.op = tsfl_pkg::OP_RELEASE;
      tsfl_pkg::ACT_READ:    cmd.op = tsfl_pkg::OP_READ;
      default:               cmd.op = tsfl_pkg::OP_NOP;
    endcase
  end

endmodule

[design/tsfl_queue.sv]
// Two-entry command queue between the front end and the state engine.
`timescale 1ns / 1ps

module tsfl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsfl_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           head_valid,
  output tsfl_pkg::cmd_t head_cmd,
  input  logic           pop
);

  tsfl_pkg::cmd_t                    mem [tsfl_pkg::Q_DEPTH];
  logic [tsfl_pkg::Q_PTR_BITS-1:0]   wr_ptr;
  logic [tsfl_pkg::Q_PTR_BITS-1:0]   rd_ptr;
  logic [tsfl_pkg::Q_PTR_BITS:0]     fill;

  assign full       = (fill == (tsfl_pkg::Q_PTR_BITS + 1)'(tsfl_pkg::Q_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue pop while empty");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (tsfl_pkg::Q_PTR_BITS + 1)'(tsfl_pkg::Q_DEPTH))
    else $error("queue fill out of range");

endmodule

[design/tsfl_back.sv]
// State engine: applies commands to the touch state and registers one result word each.
`timescale 1ns / 1ps

module tsfl_back (
  input  logic              clk,
  input  logic              rst,
  input  tsfl_pkg::cfg_t    cfg,
  input  logic              head_valid,
  input  tsfl_pkg::cmd_t    head_cmd,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output tsfl_pkg::result_t result
);

  localparam int CB = tsfl_pkg::COORD_BITS;

  logic [1:0]                   contact_count, contact_count_next;
  logic [CB-1:0]                kept_x, kept_x_next;
  logic [CB-1:0]                kept_y, kept_y_next;
  logic                         press_pending, press_pending_next;
  logic [CB-1:0]                press_x, press_x_next;
  logic [CB-1:0]                press_y, press_y_next;
  logic [tsfl_pkg::CNT_BITS-1:0] reject_counter, reject_counter_next;
  logic [tsfl_pkg::CNT_BITS-1:0] press_counter, press_counter_next;
  logic [tsfl_pkg::CNT_BITS-1:0] consume_counter, consume_counter_next;

  logic [CB-1:0]     dx;
  logic [CB-1:0]     dy;
  logic [CB:0]       manhattan;
  logic              move;
  tsfl_pkg::result_t res_next;

  assign pop = head_valid && (!result_valid || !result_stall);

  assign dx   = (kept_x > head_cmd.mx) ? kept_x - head_cmd.mx : head_cmd.mx - kept_x;
  assign dy   = (kept_y > head_cmd.my) ? kept_y - head_cmd.my : head_cmd.my - kept_y;
  assign manhattan = {1'b0, dx} + {1'b0, dy};
  assign move = (manhattan > tsfl_pkg::MOVE_THRESH) || (kept_x == '0 && kept_y == '0);

  always_comb begin
    contact_count_next   = contact_count;
    kept_x_next          = kept_x;
    kept_y_next          = kept_y;
    press_pending_next   = press_pending;
    press_x_next         = press_x;
    press_y_next         = press_y;
    reject_counter_next  = reject_counter;
    press_counter_next   = press_counter;
    consume_counter_next = consume_counter;
    res_next             = '0;
    case (head_cmd.op)
      tsfl_pkg::OP_RELEASE: contact_count_next = 2'd0;
      tsfl_pkg::OP_REJECT: begin
        contact_count_next = 2'd0;
        res_next.rejected  = 1'b1;
        if (reject_counter != tsfl_pkg::CNT_MAX) begin
          reject_counter_next = reject_counter + 1'b1;
        end
      end
      tsfl_pkg::OP_TOUCH: begin
        if (move) begin
          kept_x_next = head_cmd.mx;
          kept_y_next = head_cmd.my;
        end
        // first point of a new contact, held until a read takes it
        if (contact_count == 2'd0 && !press_pending) begin
          press_x_next       = head_cmd.mx;
          press_y_next       = head_cmd.my;
          press_pending_next = 1'b1;
          if (press_counter != tsfl_pkg::CNT_MAX) begin
            press_counter_next = press_counter + 1'b1;
          end
        end
        contact_count_next = head_cmd.count;
      end
      tsfl_pkg::OP_READ: begin
        if (cfg.device_present) begin
          if (press_pending) begin
            res_next.point_x   = press_x;
            res_next.point_y   = press_y;
            res_next.from_latch = 1'b1;
            res_next.touched   = 1'b1;
            press_pending_next = 1'b0;
            if (consume_counter != tsfl_pkg::CNT_MAX) begin
              consume_counter_next = consume_counter + 1'b1;
            end
          end else begin
            res_next.point_x = kept_x;
            res_next.point_y = kept_y;
            res_next.touched = (contact_count != 2'd0);
          end
        end
      end
      default: ;
    endcase
    res_next.error_count = reject_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      contact_count   <= '0;
      kept_x          <= '0;
      kept_y          <= '0;
      press_pending   <= 1'b0;
      press_x         <= '0;
      press_y         <= '0;
      reject_counter  <= '0;
      press_counter   <= '0;
      consume_counter <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (pop) begin
        contact_count   <= contact_count_next;
        kept_x          <= kept_x_next;
        kept_y          <= kept_y_next;
        press_pending   <= press_pending_next;
        press_x         <= press_x_next;
        press_y         <= press_y_next;
        reject_counter  <= reject_counter_next;
        press_counter   <= press_counter_next;
        consume_counter <= consume_counter_next;
        result_valid    <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= res_next;
    end
  end

  a_pop_gives_word: assert property (@(posedge clk) disable iff (rst) pop |=> result_valid)
    else $error("popped command produced no result word");
  a_press_only_on_touch: assert property (@(posedge clk) disable iff (rst)
    $rose(press_pending) |-> $past(pop && head_cmd.op == tsfl_pkg::OP_TOUCH))
    else $error("press latched without a touch report");
  a_reject_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> reject_counter >= $past(reject_counter))
    else $error("reject counter went backwards");
  a_latch_needs_pending: assert property (@(posedge clk) disable iff (rst)
    pop && head_cmd.op == tsfl_pkg::OP_READ && press_pending && cfg.device_present
    |=> !press_pending && result.from_latch)
    else $error("latched press not consumed by read");

endmodule

[design/touch_sample_filter_latch.sv]
// Top level: configuration registers, front end, command queue and state engine.
//
// Usage:
//   sample channel (sample_valid / sample_stall / sample): one report word per
//   accepted edge; action selects sample report, release or point read.
//   result channel (result_valid / result_stall / result): exactly one result
//   word per accepted sample word, in order.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes panel
//   height, panel width and device-present; cfg_ready is always high. Write
//   only while no words are in flight.
// Path: front decode writes an accepted word into the queue, and the state
//   engine registers its result when it pops that command from the queue.
// Throughput: one word per cycle while result_stall is low; the two-entry
//   queue takes one more word after result_stall rises.
// Stall: while result_stall is high the result word holds; the queue fills and
//   sample_stall rises once both entries are taken.
// Reset (rst, synchronous): queue and result emptied, touch state and counters
//   zeroed, panel 480 x 800 with device present.
`timescale 1ns / 1ps

module touch_sample_filter_latch (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  tsfl_pkg::sample_t     sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output tsfl_pkg::result_t     result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [tsfl_pkg::COORD_BITS-1:0] cfg_data
);

  tsfl_pkg::cfg_t cfg;
  tsfl_pkg::cmd_t front_cmd;
  tsfl_pkg::cmd_t head_cmd;
  logic           q_full;
  logic           head_valid;
  logic           pop;
  logic           push;

  assign cfg_ready    = 1'b1;
  assign sample_stall = q_full;
  assign push         = sample_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.panel_height   <= tsfl_pkg::PANEL_HEIGHT_RST;
      cfg.panel_width    <= tsfl_pkg::PANEL_WIDTH_RST;
      cfg.device_present <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsfl_pkg::REG_PANEL_HEIGHT:   cfg.panel_height   <= cfg_data;
        tsfl_pkg::REG_PANEL_WIDTH:    cfg.panel_width    <= cfg_data;
        tsfl_pkg::REG_DEVICE_PRESENT: cfg.device_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tsfl_front u_front (
    .sample (sample),
    .cfg    (cfg),
    .cmd    (front_cmd)
  );

  tsfl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  tsfl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
